// ===== rtl/core/iwi_pkg.sv =====
// ----------------------------------------------------------------------------
// iwi_pkg
// Shared types and constants of the implicit weight and inverse block.
// ----------------------------------------------------------------------------
package iwi_pkg;

  // Default number of fractional bits of every operand and result.
  localparam int FRAC_BITS_DEF = 16;

  // Fitted constant c at scale 2^32, and 6c-2 at the same scale.
  localparam logic [30:0] C32 = 31'd1769840059;
  localparam logic [30:0] A32 = 31'd2029105762;

  // Divider geometry: denominator width and quotient bits.
  localparam int DIV_DW = 62;
  localparam int DIV_QW = 33;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 2;

  // Register values of the curve choice.
  localparam logic [1:0] VAR_SQUARED = 2'd0;
  localparam logic [1:0] VAR_PLAIN   = 2'd1;
  localparam logic [1:0] VAR_FITTED  = 2'd2;
  localparam logic [1:0] VAR_RESET   = VAR_PLAIN;

  // Saturation limits.
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_NEGRAD = 2'd2
  } status_e;

  // Work class of a request, decided by the front.
  typedef enum logic [2:0] {
    K_ZERO = 3'd0,
    K_FWD0 = 3'd1,
    K_FWD1 = 3'd2,
    K_FWD2 = 3'd3,
    K_INV0 = 3'd4,
    K_INV1 = 3'd5,
    K_INV2 = 3'd6
  } kind_e;

  // A classified request as it sits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [30:0] mag;
  } item_t;

  // Request context carried alongside the square-root pipeline.
  typedef struct packed {
    kind_e       kind;
    logic        spc;
    status_e     spc_st;
    logic [30:0] mag;
    logic [61:0] dv;
  } sq_side_t;

  // Request context carried alongside the divider pipeline.
  typedef struct packed {
    kind_e   kind;
    logic    spc;
    status_e spc_st;
    logic    neg;
  } dv_side_t;

endpackage

// ===== rtl/core/implicit_weight_and_inverse.sv =====
// ----------------------------------------------------------------------------
// implicit_weight_and_inverse
// Fixed-point weight from a sum, and the sum from a weight, on three curves.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i / in_stall_o with req_type_i (0 forward,
//   1 inverse) and a signed operand_i with FRAC_BITS fractional bits. Each
//   request gives exactly one result on out_valid_o / out_stall_i, carrying
//   result_o and status_o, in request order.
//   The curve is chosen by a write on cfg_valid_i / cfg_ready_o with
//   cfg_data_i; ready is always high and writes belong to idle periods.
//   One request is taken every cycle while the output is not stalled.
//   RW = (FRAC_BITS + 32) / 2 rounded down is the number of stages of the
//   bit-per-stage square root; the radix-2 divider has 33 quotient stages,
//   and the front register, the queue and stages 1 to 7 lie around them.
//   A stall on a waiting result freezes the arithmetic pipeline in place; the front
//   register and a two-entry queue keep taking requests until they fill, and
//   only then is in_stall_o raised.
//   Reset empties the pipeline and the queue and selects the plain ratio.
// ----------------------------------------------------------------------------
module implicit_weight_and_inverse #(
  parameter int FRAC_BITS = iwi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  logic [1:0]     variant_q;
  logic           push, fifo_full, fifo_valid, pop;
  iwi_pkg::item_t front_item, fifo_item;
  logic [31:0]    result;

  // Curve selection register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= iwi_pkg::VAR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      variant_q <= cfg_data_i;
    end
  end

  // Front: acceptance and classification.
  iwi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .operand_i  (operand_i),
    .variant_i  (variant_q),
    .full_i     (fifo_full),
    .stall_o    (in_stall_o),
    .push_o     (push),
    .item_o     (front_item)
  );

  // Queue between front and back.
  iwi_fifo #(.DEPTH(iwi_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  // Back: arithmetic pipeline and output register.
  iwi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fifo_valid),
    .item_i      (fifo_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result),
    .status_o    (status_o)
  );

  assign result_o = $signed(result);

  // The front only moves a request on when the queue has room for it.
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("request pushed into a full queue");

  // A negative radicand always comes with a zero result.
  a_negrad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == iwi_pkg::ST_NEGRAD)) |-> (result_o == 32'sd0))
    else $error("negative radicand with a non-zero result");

  // Saturated results sit at one of the two limits.
  a_sat_limits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == iwi_pkg::ST_SAT)) |->
      ((result == iwi_pkg::POS_MAX) || (result == iwi_pkg::NEG_MAX)))
    else $error("saturated result off the limits");

endmodule

// ===== rtl/core/iwi_front.sv =====
// ----------------------------------------------------------------------------
// iwi_front
// Accepts requests, classifies them by curve and direction, and hands them on.
// ----------------------------------------------------------------------------
module iwi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                req_type_i,
  input  logic signed [31:0]  operand_i,
  input  logic [1:0]          variant_i,
  input  logic                full_i,
  output logic                stall_o,
  output logic                push_o,
  output iwi_pkg::item_t      item_o
);

  logic           hold_q, hold_d;
  iwi_pkg::item_t item_q, item_d;
  logic           accept;
  logic           pos;

  // The holding register moves on whenever the queue has room.
  assign push_o  = hold_q && !full_i;
  assign stall_o = hold_q && full_i;
  assign accept  = valid_i && !stall_o;
  assign item_o  = item_q;

  // Classification: non-positive operands and the unused curve give zero.
  always_comb begin
    pos         = !operand_i[31] && (operand_i != 32'sd0);
    item_d.mag  = operand_i[30:0];
    item_d.kind = iwi_pkg::K_ZERO;
    if (pos) begin
      case (variant_i)
        iwi_pkg::VAR_SQUARED: item_d.kind = req_type_i ? iwi_pkg::K_INV0 : iwi_pkg::K_FWD0;
        iwi_pkg::VAR_PLAIN:   item_d.kind = req_type_i ? iwi_pkg::K_INV1 : iwi_pkg::K_FWD1;
        iwi_pkg::VAR_FITTED:  item_d.kind = req_type_i ? iwi_pkg::K_INV2 : iwi_pkg::K_FWD2;
        default:              item_d.kind = iwi_pkg::K_ZERO;
      endcase
    end
    hold_d = accept ? 1'b1 : (push_o ? 1'b0 : hold_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/iwi_fifo.sv =====
// ----------------------------------------------------------------------------
// iwi_fifo
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module iwi_fifo #(
  parameter int DEPTH = iwi_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  iwi_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output iwi_pkg::item_t item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  iwi_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/iwi_sqrt.sv =====
// ----------------------------------------------------------------------------
// iwi_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module iwi_sqrt #(
  parameter  int XW = 47,
  localparam int RW = (XW + 1) / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [XW-1:0]     x_i,
  input  iwi_pkg::sq_side_t side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output iwi_pkg::sq_side_t side_o
);

  localparam int XE = 2 * RW;

  logic              v_q    [RW];
  logic [XE-1:0]     x_q    [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  iwi_pkg::sq_side_t side_q [RW];

  for (genvar g = 0; g < RW; g++) begin : g_step
    logic              v_p;
    logic [XE-1:0]     x_p;
    logic [RW+1:0]     rem_p;
    logic [RW-1:0]     root_p;
    iwi_pkg::sq_side_t side_p;
    logic [RW+3:0]     remn, trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_p    = valid_i;
      assign x_p    = XE'(x_i);
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign v_p    = v_q[g-1];
      assign x_p    = x_q[g-1];
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign side_p = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      remn  = {rem_p, x_p[XE-1 -: 2]};
      trial = (RW + 4)'({root_p, 2'b01});
      ge    = (remn >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g]    <= {x_p[XE-3:0], 2'b00};
        rem_q[g]  <= ge ? (RW + 2)'(remn - trial) : (RW + 2)'(remn);
        root_q[g] <= {root_p[RW-2:0], ge};
        side_q[g] <= side_p;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== rtl/core/iwi_div.sv =====
// ----------------------------------------------------------------------------
// iwi_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// check ahead of the first step.
// ----------------------------------------------------------------------------
module iwi_div #(
  parameter int NW = 79,
  parameter int DW = iwi_pkg::DIV_DW,
  parameter int QW = iwi_pkg::DIV_QW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     n_i,
  input  logic [DW-1:0]     d_i,
  input  iwi_pkg::dv_side_t side_i,
  output logic              valid_o,
  output logic [QW-1:0]     q_o,
  output logic              ovf_o,
  output iwi_pkg::dv_side_t side_o
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic              v_q    [QW+1];
  logic [DW-1:0]     r_q    [QW+1];
  logic [DW-1:0]     d_q    [QW+1];
  logic [QW-1:0]     l_q    [QW+1];
  logic              ovf_q  [QW+1];
  iwi_pkg::dv_side_t side_q [QW+1];

  logic [HW-1:0] hi;
  logic          ovf0;

  // A quotient that does not fit in QW bits is flagged up front.
  assign hi   = n_i[NW-1:QW];
  assign ovf0 = (CW'(hi) >= CW'(d_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= ovf0 ? '0 : DW'(hi);
      d_q[0]    <= d_i;
      l_q[0]    <= n_i[QW-1:0];
      ovf_q[0]  <= ovf0;
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 1; g <= QW; g++) begin : g_step
    logic [DW:0] t, dx;
    logic        ge;

    // Shift in the next numerator bit and subtract where it fits.
    always_comb begin
      t  = {r_q[g-1], l_q[g-1][QW-1]};
      dx = {1'b0, d_q[g-1]};
      ge = (t >= dx);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]    <= ge ? DW'(t - dx) : DW'(t);
        d_q[g]    <= d_q[g-1];
        l_q[g]    <= {l_q[g-1][QW-2:0], ge};
        ovf_q[g]  <= ovf_q[g-1];
        side_q[g] <= side_q[g-1];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign q_o     = l_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== rtl/core/iwi_back.sv =====
// ----------------------------------------------------------------------------
// iwi_back
// Arithmetic pipeline: products, square root, divider set-up, division and
// result packing, with the output register at its end.
// ----------------------------------------------------------------------------
module iwi_back #(
  parameter int FRAC_BITS = iwi_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  iwi_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    result_o,
  output logic [1:0]     status_o
);

  localparam int XW = 31 + FRAC_BITS;
  localparam int RW = (XW + 1) / 2;
  localparam int NW = FRAC_BITS + 63;
  localparam int DW = iwi_pkg::DIV_DW;
  localparam int QW = iwi_pkg::DIV_QW;
  localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF3 = 64'd3 << (FRAC_BITS - 1);
  localparam logic [63:0] ONE_H = 64'd3 << (2 * FRAC_BITS - 1);

  logic en;

  // The whole pipeline advances unless a result waits at a stalled output.
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en;

  // ---- Stage 1: squares and the linear term ----
  logic          s1_v_q;
  iwi_pkg::kind_e s1_kind_q;
  logic [30:0]   s1_x_q;
  logic [61:0]   s1_t_q;
  logic [29:0]   s1_aw_q;
  logic [61:0]   sq1, pa1;

  assign sq1 = 62'(item_i.mag) * 62'(item_i.mag);
  assign pa1 = 62'(iwi_pkg::A32) * 62'(item_i.mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= item_i.kind;
      s1_x_q    <= item_i.mag;
      s1_t_q    <= sq1 >> FRAC_BITS;
      s1_aw_q   <= pa1[61:32];
    end
  end

  // ---- Stage 2: the square scaled by c or by 6c-2, in two halves ----
  logic          s2_v_q;
  iwi_pkg::kind_e s2_kind_q;
  logic [30:0]   s2_x_q;
  logic [61:0]   s2_t_q;
  logic [29:0]   s2_aw_q;
  logic [60:0]   s2_ph_q;
  logic [30:0]   s2_pl_q;
  logic [30:0]   k2;
  logic [62:0]   pl2;

  assign k2  = (s1_kind_q == iwi_pkg::K_FWD2) ? iwi_pkg::C32 : iwi_pkg::A32;
  assign pl2 = 63'(s1_t_q[31:0]) * 63'(k2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_kind_q <= s1_kind_q;
      s2_x_q    <= s1_x_q;
      s2_t_q    <= s1_t_q;
      s2_aw_q   <= s1_aw_q;
      s2_ph_q   <= 61'(s1_t_q[61:32]) * 61'(k2);
      s2_pl_q   <= pl2[62:32];
    end
  end

  // ---- Stage 3: fitted denominator, radicand and square-root operand ----
  logic              s3_v_q;
  logic [XW-1:0]     s3_sx_q;
  iwi_pkg::sq_side_t s3_side_q;
  logic [63:0]       mq3, d3, bw3, sa3, rad3;
  logic              negr3;
  logic [XW-1:0]     sx3;
  iwi_pkg::sq_side_t side3;

  always_comb begin
    mq3   = 64'(s2_ph_q) + 64'(s2_pl_q);
    d3    = 64'(s2_x_q) + mq3 + HALF3;
    bw3   = 64'(s2_t_q) + mq3;
    sa3   = ONE + 64'(s2_aw_q);
    negr3 = (sa3 < bw3);
    rad3  = sa3 - bw3;
    sx3   = '0;
    side3.kind   = s2_kind_q;
    side3.spc    = (s2_kind_q == iwi_pkg::K_ZERO);
    side3.spc_st = iwi_pkg::ST_OK;
    side3.mag    = s2_x_q;
    side3.dv     = d3[61:0];
    case (s2_kind_q)
      iwi_pkg::K_INV0: sx3 = XW'(s2_x_q) << FRAC_BITS;
      iwi_pkg::K_INV2: begin
        if (negr3) begin
          side3.spc    = 1'b1;
          side3.spc_st = iwi_pkg::ST_NEGRAD;
        end else begin
          sx3 = XW'(rad3[30:0]) << FRAC_BITS;
        end
      end
      default: sx3 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sx_q   <= sx3;
      s3_side_q <= side3;
    end
  end

  // ---- Square root ----
  logic              sq_v;
  logic [RW-1:0]     sq_rt;
  iwi_pkg::sq_side_t sq_side;

  iwi_sqrt #(.XW(XW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .x_i     (s3_sx_q),
    .side_i  (s3_side_q),
    .valid_o (sq_v),
    .root_o  (sq_rt),
    .side_o  (sq_side)
  );

  // ---- Stage 4: numerator, denominator and sign of the quotient ----
  logic              s4_v_q;
  logic [NW-1:0]     s4_n_q;
  logic [DW-1:0]     s4_dp_q;
  logic              s4_mul_q;
  iwi_pkg::dv_side_t s4_side_q;
  logic [NW-1:0]     n4;
  logic [DW-1:0]     dp4;
  logic              mul4;
  iwi_pkg::dv_side_t side4;
  logic [32:0]       one4, x4, rt4, r4, sum4, mag4, dm4;
  logic              ddneg4, numneg4;
  logic [63:0]       fn4;

  always_comb begin
    one4 = 33'(ONE);
    x4   = 33'(sq_side.mag);
    rt4  = 33'(sq_rt);
    r4   = (sq_side.kind == iwi_pkg::K_INV0) ? rt4 : x4;
    sum4 = rt4 + x4;
    numneg4 = (sum4 < one4);
    mag4 = numneg4 ? (one4 - sum4) : (sum4 - one4);
    ddneg4 = (x4 > one4);
    dm4  = ddneg4 ? (x4 - one4) : (one4 - x4);
    fn4  = ONE_H + 64'(sq_side.dv) - 64'd1;
    n4   = '0;
    dp4  = DW'(1);
    mul4 = 1'b0;
    side4.kind   = sq_side.kind;
    side4.spc    = sq_side.spc;
    side4.spc_st = sq_side.spc_st;
    side4.neg    = 1'b0;
    if (!sq_side.spc) begin
      case (sq_side.kind)
        iwi_pkg::K_FWD0, iwi_pkg::K_FWD1: begin
          n4  = NW'(sq_side.mag) << FRAC_BITS;
          dp4 = DW'(x4 + one4);
        end
        iwi_pkg::K_FWD2: begin
          n4  = NW'(fn4);
          dp4 = sq_side.dv;
        end
        iwi_pkg::K_INV0, iwi_pkg::K_INV1: begin
          if (r4 == one4) begin
            side4.spc    = 1'b1;
            side4.spc_st = iwi_pkg::ST_SAT;
          end else begin
            side4.neg = (r4 > one4);
            n4  = NW'(r4) << FRAC_BITS;
            dp4 = (r4 > one4) ? DW'(r4 - one4) : DW'(one4 - r4);
          end
        end
        iwi_pkg::K_INV2: begin
          side4.neg = numneg4 ^ ddneg4;
          if (x4 == one4) begin
            side4.spc    = 1'b1;
            side4.spc_st = iwi_pkg::ST_SAT;
            side4.neg    = 1'b0;
          end else if (mag4[32]) begin
            side4.spc    = 1'b1;
            side4.spc_st = iwi_pkg::ST_SAT;
          end else begin
            n4   = NW'(mag4[31:0]) << (FRAC_BITS + 31);
            dp4  = DW'(dm4);
            mul4 = 1'b1;
          end
        end
        default: begin
          side4.spc    = 1'b1;
          side4.spc_st = iwi_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_n_q    <= n4;
      s4_dp_q   <= dp4;
      s4_mul_q  <= mul4;
      s4_side_q <= side4;
    end
  end

  // ---- Stage 5: fitted inverse denominator scaled by c ----
  logic              s5_v_q;
  logic [NW-1:0]     s5_n_q;
  logic [DW-1:0]     s5_d_q;
  iwi_pkg::dv_side_t s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_n_q    <= s4_n_q;
      s5_d_q    <= s4_mul_q ? DW'(62'(s4_dp_q[30:0]) * 62'(iwi_pkg::C32)) : s4_dp_q;
      s5_side_q <= s4_side_q;
    end
  end

  // ---- Division ----
  logic              dv_v;
  logic [QW-1:0]     dv_q;
  logic              dv_ovf;
  iwi_pkg::dv_side_t dv_side;

  iwi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .n_i     (s5_n_q),
    .d_i     (s5_d_q),
    .side_i  (s5_side_q),
    .valid_o (dv_v),
    .q_o     (dv_q),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // ---- Stage 6: square of the ratio for the squared curve ----
  logic              s6_v_q;
  logic [QW-1:0]     s6_q_q;
  logic              s6_ovf_q;
  logic [61:0]       s6_sq_q;
  iwi_pkg::dv_side_t s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q_q    <= dv_q;
      s6_ovf_q  <= dv_ovf;
      s6_sq_q   <= 62'(dv_q[30:0]) * 62'(dv_q[30:0]);
      s6_side_q <= dv_side;
    end
  end

  // ---- Stage 7: packing and saturation into the output register ----
  logic          out_v_q;
  logic [31:0]   res_q, res7;
  logic [1:0]    st_q;
  iwi_pkg::status_e st7;
  logic          big7;
  logic [61:0]   w7;

  always_comb begin
    big7 = s6_ovf_q || s6_q_q[32];
    w7   = s6_sq_q >> FRAC_BITS;
    res7 = 32'd0;
    st7  = iwi_pkg::ST_OK;
    if (s6_side_q.spc) begin
      st7 = s6_side_q.spc_st;
      if (s6_side_q.spc_st == iwi_pkg::ST_SAT) begin
        res7 = s6_side_q.neg ? iwi_pkg::NEG_MAX : iwi_pkg::POS_MAX;
      end
    end else begin
      case (s6_side_q.kind)
        iwi_pkg::K_FWD0: res7 = w7[31:0];
        iwi_pkg::K_FWD1: res7 = s6_q_q[31:0];
        iwi_pkg::K_FWD2: res7 = 32'(ONE) - s6_q_q[31:0];
        iwi_pkg::K_INV0, iwi_pkg::K_INV1, iwi_pkg::K_INV2: begin
          if (!s6_side_q.neg) begin
            if (big7 || s6_q_q[31]) begin
              res7 = iwi_pkg::POS_MAX;
              st7  = iwi_pkg::ST_SAT;
            end else begin
              res7 = s6_q_q[31:0];
            end
          end else begin
            if (big7 || (s6_q_q[31] && (s6_q_q[30:0] != 31'd0))) begin
              res7 = iwi_pkg::NEG_MAX;
              st7  = iwi_pkg::ST_SAT;
            end else begin
              res7 = 32'd0 - s6_q_q[31:0];
            end
          end
        end
        default: res7 = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res7;
      st_q  <= st7;
    end
  end

  assign out_valid_o = out_v_q;
  assign result_o    = res_q;
  assign status_o    = st_q;

endmodule
